[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/nfb_pkg.sv]
package nfb_pkg;

    localparam int FrameBytes = 262144;
    localparam int AddrW = 18;
    localparam int RowBytes = 512;
    localparam int RowAddrW = 9;
    localparam int MaxLinePixels = 1024;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_BLIT  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        op_t         op;
        logic        refuse;
        logic [17:0] addr;
        logic [7:0]  wdata;
        logic [20:0] src_p;
        logic [20:0] dst_p;
        logic [20:0] row_step;
        logic        bottom_up;
        logic [10:0] width;
        logic [10:0] height;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RD_REQ,
        BK_RD_WAIT,
        BK_WR_REQ,
        BK_WR_STORE,
        BK_DONE
    } back_state_t;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_MUL1,
        FR_MUL2,
        FR_CHECK,
        FR_PUSH
    } front_state_t;

endpackage

[hdl/nfb_front.sv]
module nfb_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            op,
    input  logic [17:0]           byte_addr,
    input  logic [7:0]            write_data,
    input  logic [9:0]            src_x,
    input  logic [9:0]            src_y,
    input  logic [9:0]            dst_x,
    input  logic [9:0]            dst_y,
    input  logic [10:0]           rect_width,
    input  logic [10:0]           rect_height,
    input  logic [10:0]           line_width,
    output logic                  cmd_valid,
    output nfb_pkg::cmd_t         cmd,
    input  logic                  cmd_full
);

    nfb_pkg::front_state_t state_reg, state_next;
    nfb_pkg::cmd_t         cmd_reg, cmd_next;
    logic [9:0]  sx_reg, sy_reg, dx_reg, dy_reg;
    logic [10:0] lw_reg;
    logic [21:0] prod;
    logic [9:0]  y_sel;

    // Shared multiplier: row number times line width.
    always_comb
    begin
        y_sel = (state_reg == nfb_pkg::FR_MUL1) ? sy_reg : dy_reg;
        prod = 22'(y_sel) * 22'(lw_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nfb_pkg::FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (state_reg == nfb_pkg::FR_IDLE && in_valid)
        begin
            sx_reg <= src_x;
            sy_reg <= src_y;
            dx_reg <= dst_x;
            dy_reg <= dst_y;
            lw_reg <= {line_width[10:1], 1'b0};
        end
    end

    // Accept, compute rectangle start addresses and check sizes for blits, then push.
    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        in_stall = 1'b1;
        cmd_valid = 1'b0;
        unique case (state_reg)
            nfb_pkg::FR_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd_next.op = nfb_pkg::op_t'(op);
                    cmd_next.addr = byte_addr;
                    cmd_next.wdata = write_data;
                    cmd_next.width = rect_width;
                    cmd_next.height = rect_height;
                    cmd_next.bottom_up = src_y < dst_y;
                    cmd_next.refuse = 1'b0;
                    cmd_next.row_step = {10'd0, line_width[10:1], 1'b0};
                    if (op == nfb_pkg::OP_BLIT)
                        state_next = nfb_pkg::FR_MUL1;
                    else
                        state_next = nfb_pkg::FR_PUSH;
                end
            end
            nfb_pkg::FR_MUL1:
            begin
                cmd_next.src_p = 21'(prod + 22'(sx_reg));
                state_next = nfb_pkg::FR_MUL2;
            end
            nfb_pkg::FR_MUL2:
            begin
                cmd_next.dst_p = 21'(prod + 22'(dx_reg));
                state_next = nfb_pkg::FR_CHECK;
            end
            nfb_pkg::FR_CHECK:
            begin
                // Empty and too-wide rectangles are settled here; memory bounds in the back.
                state_next = nfb_pkg::FR_PUSH;
                if (cmd_reg.width == 11'd0 || cmd_reg.height == 11'd0)
                begin
                    cmd_next.op = nfb_pkg::OP_NONE;
                end
                else if (cmd_reg.width > 11'(nfb_pkg::MaxLinePixels))
                begin
                    cmd_next.refuse = 1'b1;
                end
            end
            nfb_pkg::FR_PUSH:
            begin
                cmd_valid = 1'b1;
                if (!cmd_full)
                    state_next = nfb_pkg::FR_IDLE;
            end
            default:
            begin
                state_next = nfb_pkg::FR_IDLE;
            end
        endcase
    end

    assign cmd = cmd_reg;

endmodule

[hdl/nfb_back.sv]
module nfb_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  nfb_pkg::cmd_t   cmd,
    output logic            cmd_pop,
    output logic            res_valid,
    output logic [7:0]      res_rdata,
    output logic            res_status,
    input  logic            res_stall
);

    logic [7:0] frame_mem [nfb_pkg::FrameBytes];
    logic [7:0] row_mem [nfb_pkg::RowBytes];

    nfb_pkg::back_state_t state_reg, state_next;
    nfb_pkg::cmd_t cmd_reg;
    logic [21:0] sp_reg, sp_next, dp_reg, dp_next;
    logic [10:0] i_reg, i_next, k_reg, k_next;
    logic [7:0]  rd_q;
    logic [7:0]  rb_q;
    logic [7:0]  rdata_reg, rdata_next;
    logic        status_reg, status_next;
    logic        chk_reg, chk_next;
    logic        mem_we;
    logic [17:0] mem_addr;
    logic [7:0]  mem_wdata;
    logic        rb_we;
    logic [8:0]  rb_addr;
    logic [7:0]  rb_wdata;
    logic [21:0] cur_p;
    logic [3:0]  nib;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[mem_addr] <= mem_wdata;
        rd_q <= frame_mem[mem_addr];
        if (rb_we)
            row_mem[rb_addr] <= rb_wdata;
        rb_q <= row_mem[rb_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nfb_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
            cmd_reg <= cmd;
        sp_reg <= sp_next;
        dp_reg <= dp_next;
        i_reg <= i_next;
        k_reg <= k_next;
        rdata_reg <= rdata_next;
        status_reg <= status_next;
        chk_reg <= chk_next;
    end

    // Blit: read each row into the buffer nibble by nibble, then write it out.
    always_comb
    begin
        state_next = state_reg;
        sp_next = sp_reg;
        dp_next = dp_reg;
        i_next = i_reg;
        k_next = k_reg;
        rdata_next = rdata_reg;
        status_next = status_reg;
        chk_next = chk_reg;
        cmd_pop = 1'b0;
        res_valid = 1'b0;
        mem_we = 1'b0;
        mem_addr = cmd_reg.addr;
        mem_wdata = cmd_reg.wdata;
        rb_we = 1'b0;
        rb_addr = i_reg[9:1];
        rb_wdata = rb_q;
        cur_p = 22'd0;
        nib = 4'd0;
        unique case (state_reg)
            nfb_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    rdata_next = 8'd0;
                    status_next = cmd.refuse;
                    i_next = 11'd0;
                    k_next = 11'd0;
                    mem_addr = cmd.addr;
                    if (cmd.refuse || cmd.op == nfb_pkg::OP_NONE)
                        state_next = nfb_pkg::BK_DONE;
                    else if (cmd.op == nfb_pkg::OP_WRITE || cmd.op == nfb_pkg::OP_READ)
                        state_next = nfb_pkg::BK_RD_WAIT;
                    else
                    begin
                        // Bounds: bottom row offset added row by row while checking.
                        sp_next = 22'(cmd.src_p) + 22'(cmd.width) - 22'd1;
                        dp_next = 22'(cmd.dst_p) + 22'(cmd.width) - 22'd1;
                        chk_next = 1'b1;
                        state_next = nfb_pkg::BK_RD_REQ;
                    end
                end
            end
            nfb_pkg::BK_RD_REQ:
            begin
                if (chk_reg)
                begin
                    // Step last-pixel sums down (h-1) rows, one add per cycle.
                    if (k_reg + 11'd1 < cmd_reg.height)
                    begin
                        sp_next = sp_reg + 22'(cmd_reg.row_step);
                        dp_next = dp_reg + 22'(cmd_reg.row_step);
                        k_next = k_reg + 11'd1;
                    end
                    else
                    begin
                        if (sp_reg[21:1] >= 21'(nfb_pkg::FrameBytes)
                            || dp_reg[21:1] >= 21'(nfb_pkg::FrameBytes))
                        begin
                            status_next = 1'b1;
                            state_next = nfb_pkg::BK_DONE;
                        end
                        chk_next = 1'b0;
                        k_next = 11'd0;
                        if (cmd_reg.bottom_up)
                        begin
                            sp_next = sp_reg - 22'(cmd_reg.width) + 22'd1;
                            dp_next = dp_reg - 22'(cmd_reg.width) + 22'd1;
                        end
                        else
                        begin
                            sp_next = 22'(cmd_reg.src_p);
                            dp_next = 22'(cmd_reg.dst_p);
                        end
                    end
                end
                else
                begin
                    cur_p = sp_reg + 22'(i_reg);
                    mem_addr = cur_p[18:1];
                    state_next = nfb_pkg::BK_RD_WAIT;
                end
            end
            nfb_pkg::BK_RD_WAIT:
            begin
                if (cmd_reg.op == nfb_pkg::OP_WRITE)
                begin
                    mem_we = 1'b1;
                    state_next = nfb_pkg::BK_DONE;
                end
                else if (cmd_reg.op == nfb_pkg::OP_READ)
                begin
                    rdata_next = rd_q;
                    state_next = nfb_pkg::BK_DONE;
                end
                else
                begin
                    // Merge the fetched nibble into its row buffer byte.
                    cur_p = sp_reg + 22'(i_reg);
                    nib = cur_p[0] ? rd_q[7:4] : rd_q[3:0];
                    rb_addr = i_reg[9:1];
                    rb_we = 1'b1;
                    rb_wdata = i_reg[0] ? {nib, rb_q[3:0]} : {4'd0, nib};
                    i_next = i_reg + 11'd1;
                    if (i_reg + 11'd1 == cmd_reg.width)
                    begin
                        i_next = 11'd0;
                        state_next = nfb_pkg::BK_WR_REQ;
                    end
                    else
                        state_next = nfb_pkg::BK_RD_REQ;
                end
            end
            nfb_pkg::BK_WR_REQ:
            begin
                cur_p = dp_reg + 22'(i_reg);
                mem_addr = cur_p[18:1];
                rb_addr = i_reg[9:1];
                state_next = nfb_pkg::BK_WR_STORE;
            end
            nfb_pkg::BK_WR_STORE:
            begin
                cur_p = dp_reg + 22'(i_reg);
                mem_addr = cur_p[18:1];
                nib = i_reg[0] ? rb_q[7:4] : rb_q[3:0];
                mem_we = 1'b1;
                mem_wdata = cur_p[0] ? {nib, rd_q[3:0]} : {rd_q[7:4], nib};
                i_next = i_reg + 11'd1;
                state_next = nfb_pkg::BK_WR_REQ;
                if (i_reg + 11'd1 == cmd_reg.width)
                begin
                    i_next = 11'd0;
                    k_next = k_reg + 11'd1;
                    if (cmd_reg.bottom_up)
                    begin
                        sp_next = sp_reg - 22'(cmd_reg.row_step);
                        dp_next = dp_reg - 22'(cmd_reg.row_step);
                    end
                    else
                    begin
                        sp_next = sp_reg + 22'(cmd_reg.row_step);
                        dp_next = dp_reg + 22'(cmd_reg.row_step);
                    end
                    if (k_reg + 11'd1 == cmd_reg.height)
                        state_next = nfb_pkg::BK_DONE;
                    else
                        state_next = nfb_pkg::BK_RD_REQ;
                end
            end
            nfb_pkg::BK_DONE:
            begin
                res_valid = 1'b1;
                if (!res_stall)
                    state_next = nfb_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = nfb_pkg::BK_IDLE;
            end
        endcase
    end

    assign res_rdata = rdata_reg;
    assign res_status = status_reg;

endmodule

[hdl/nfb_queue.sv]
module nfb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  nfb_pkg::cmd_t   push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output nfb_pkg::cmd_t   head
);

    nfb_pkg::cmd_t slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rp_reg, wp_reg;

    // Two-entry command queue between front and back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rp_reg <= 1'b0;
            wp_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push && !full)
                wp_reg <= ~wp_reg;
            if (pop && not_empty)
                rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            slot_reg[wp_reg] <= push_cmd;
    end

    always_comb
    begin
        cnt_next = cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
    end

    assign full = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign head = slot_reg[rp_reg];

endmodule

[hdl/nibble_framebuffer_blit.sv]
// Host write or read: front, command queue, then the back end in three steps (fetch,
// memory access, result); the back end takes the next request once the result is taken.
// Blit: after the front computes start addresses, the back end checks bounds row by row,
// then each pixel takes a read and a read-modify-write on the single frame memory port.
// Empty or too-wide blits answer with no bound check, out-of-range ones after it.
// Reset (rst_n, asynchronous, active low) clears control state and sets line_width to 640.
`include "assert_macros.svh"

module nibble_framebuffer_blit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [17:0] byte_addr,
    input  logic [7:0]  write_data,
    input  logic [9:0]  src_x,
    input  logic [9:0]  src_y,
    input  logic [9:0]  dst_x,
    input  logic [9:0]  dst_y,
    input  logic [10:0] rect_width,
    input  logic [10:0] rect_height,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [10:0] line_width_reg;
    logic        f_valid, q_full, q_ne, q_pop;
    nfb_pkg::cmd_t f_cmd, q_head;
    logic        host_addr_bad;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_width_reg <= 11'd640;
        else if (psel && penable && pwrite && paddr == 2'd0)
            line_width_reg <= pwdata[10:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {21'd0, line_width_reg} : 32'd0;
    assign host_addr_bad = 1'b0;

    nfb_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .byte_addr(byte_addr), .write_data(write_data),
        .src_x(src_x), .src_y(src_y), .dst_x(dst_x), .dst_y(dst_y),
        .rect_width(rect_width), .rect_height(rect_height),
        .line_width(line_width_reg), .cmd_valid(f_valid), .cmd(f_cmd), .cmd_full(q_full)
    );

    nfb_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(f_valid), .push_cmd(f_cmd), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .head(q_head)
    );

    nfb_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(q_ne), .cmd(q_head), .cmd_pop(q_pop),
        .res_valid(out_valid), .res_rdata(read_data), .res_status(status),
        .res_stall(out_stall)
    );

    `ASSERT_IMPL(a_pop_needs_entry, q_pop, q_ne)
    `ASSERT_IMPL(a_no_ready_fault, out_valid, !host_addr_bad)
    `ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid && $stable(read_data))

endmodule
